// ===== src/tmmv_pkg.sv =====
// Shared widths, constants and record types for the tile statistics block.
// Used by the front end, the item queue and the statistics back end.
package tmmv_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int FRAME_W    = 8;
    localparam int TILE_TAG_W = 16;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int SUM_W      = 16;
    localparam int SUMSQ_W    = 24;
    localparam int COUNT_W    = 7;
    localparam int MEAN_SHIFT = 6;
    localparam int SQS_W      = SUMSQ_W - MEAN_SHIFT;
    localparam int VAR_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    // One classified pixel, handed from the front end to the back end.
    typedef struct packed {
        logic [PIX_W-1:0]      pixel;
        logic [SQ_W-1:0]       square;
        logic                  bank;
        logic                  last;
        logic [FRAME_W-1:0]    frame;
        logic [TILE_TAG_W-1:0] tile;
    } tmmv_item_t;

    // Completed tile figures before the variance subtraction.
    typedef struct packed {
        logic [PIX_W-1:0]      min_val;
        logic [PIX_W-1:0]      max_val;
        logic [PIX_W-1:0]      mean;
        logic [SQS_W-1:0]      sqs;
        logic [FRAME_W-1:0]    frame;
        logic [TILE_TAG_W-1:0] tile;
    } tmmv_tile_t;

endpackage

// ===== src/tmmv_front.sv =====
// Front end: accepts pixel beats, finds the tile position and bank and squares the pixel.
// Two elastic stages; depends on tmmv_pkg.
module tmmv_front #(
    parameter int TILE_W          = 8,
    parameter int TILE_H          = 8,
    parameter int BANK_SELECT_BIT = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [tmmv_pkg::PIX_W-1:0]       pixel_value,
    input  logic [tmmv_pkg::COORD_W-1:0]     x_coord,
    input  logic [tmmv_pkg::COORD_W-1:0]     y_coord,
    input  logic [tmmv_pkg::FRAME_W-1:0]     frame_number,
    input  logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number,
    output logic                             item_valid,
    input  logic                             item_ready,
    output tmmv_pkg::tmmv_item_t             item
);
    import tmmv_pkg::*;

    // Reciprocal constants: floor(c * R >> S) equals c / TILE for every 12-bit c.
    localparam int SHIFT_X = COORD_W + $clog2(TILE_W);
    localparam int SHIFT_Y = COORD_W + $clog2(TILE_H);
    localparam int RECIP_W = COORD_W + 1;
    localparam int PROD_W  = COORD_W + RECIP_W;
    localparam int RECIP_X = (2 ** SHIFT_X + TILE_W - 1) / TILE_W;
    localparam int RECIP_Y = (2 ** SHIFT_Y + TILE_H - 1) / TILE_H;

    logic                  a_valid_reg, a_valid_next;
    logic [PIX_W-1:0]      a_pixel_reg;
    logic [COORD_W-1:0]    a_x_reg;
    logic [COORD_W-1:0]    a_y_reg;
    logic [COORD_W-1:0]    a_qx_reg;
    logic [COORD_W-1:0]    a_qy_reg;
    logic [FRAME_W-1:0]    a_frame_reg;
    logic [TILE_TAG_W-1:0] a_tile_reg;

    logic                  b_valid_reg, b_valid_next;
    tmmv_item_t            b_item_reg, b_item_next;

    logic                  a_ready, b_ready;
    logic [PROD_W-1:0]     x_prod, y_prod;
    logic [COORD_W-1:0]    x_base, y_base, x_rem, y_rem;

    // Stage handshakes: a stage takes a beat when empty or draining.
    assign b_ready     = !b_valid_reg || item_ready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign pixel_ready = a_ready;
    assign item_valid  = b_valid_reg;
    assign item        = b_item_reg;

    // Quotients by the tile size through reciprocal multiplication.
    assign x_prod = PROD_W'(x_coord) * PROD_W'(RECIP_X);
    assign y_prod = PROD_W'(y_coord) * PROD_W'(RECIP_Y);

    // Remainders, last-pixel test, bank choice and the pixel square.
    always_comb
    begin
        x_base = a_qx_reg * COORD_W'(TILE_W);
        y_base = a_qy_reg * COORD_W'(TILE_H);
        x_rem  = a_x_reg - x_base;
        y_rem  = a_y_reg - y_base;
        b_item_next.pixel  = a_pixel_reg;
        b_item_next.square = SQ_W'(a_pixel_reg) * SQ_W'(a_pixel_reg);
        b_item_next.bank   = a_x_reg[BANK_SELECT_BIT];
        b_item_next.last   = (x_rem == COORD_W'(TILE_W - 1)) &&
                             (y_rem == COORD_W'(TILE_H - 1));
        b_item_next.frame  = a_frame_reg;
        b_item_next.tile   = a_tile_reg;
    end

    // Valid flags for both stages.
    always_comb
    begin
        a_valid_next = a_ready ? pixel_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (a_ready && pixel_valid)
        begin
            a_pixel_reg <= pixel_value;
            a_x_reg     <= x_coord;
            a_y_reg     <= y_coord;
            a_qx_reg    <= COORD_W'(x_prod >> SHIFT_X);
            a_qy_reg    <= COORD_W'(y_prod >> SHIFT_Y);
            a_frame_reg <= frame_number;
            a_tile_reg  <= tile_number;
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

endmodule

// ===== src/tmmv_queue.sv =====
// Two-entry queue that decouples the front end from the statistics back end.
// Depends on tmmv_pkg for the item record.
module tmmv_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  tmmv_pkg::tmmv_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output tmmv_pkg::tmmv_item_t pop_item
);
    import tmmv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tmmv_item_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/tmmv_back.sv =====
// Back end: two accumulator banks, tile completion and the variance output stage.
// Depends on tmmv_pkg for widths and record types.
module tmmv_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  tmmv_pkg::tmmv_item_t             item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [tmmv_pkg::PIX_W-1:0]       min_value,
    output logic [tmmv_pkg::PIX_W-1:0]       max_value,
    output logic [tmmv_pkg::PIX_W-1:0]       mean_value,
    output logic [tmmv_pkg::VAR_W-1:0]       variance_value,
    output logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number_out,
    output logic [tmmv_pkg::FRAME_W-1:0]     frame_number_out
);
    import tmmv_pkg::*;

    logic [PIX_W-1:0]   min_reg   [2];
    logic [PIX_W-1:0]   max_reg   [2];
    logic [SUM_W-1:0]   sum_reg   [2];
    logic [SUMSQ_W-1:0] sumsq_reg [2];
    logic [COUNT_W-1:0] count_reg [2];

    logic [PIX_W-1:0]   min_next, max_next;
    logic [SUM_W-1:0]   sum_next;
    logic [SUMSQ_W-1:0] sumsq_next;
    logic [COUNT_W-1:0] count_next;
    logic               fresh, fire;

    logic               s1_valid_reg, s1_valid_next;
    tmmv_tile_t         s1_reg, s1_next;
    logic               s1_ready, out_ready;

    logic               result_valid_reg, result_valid_next;
    logic [SQ_W-1:0]    mean_sq;
    logic [SQS_W-1:0]   var_full;

    // A non-final beat never waits; a final beat waits for room in the tile stage.
    assign out_ready  = !result_valid_reg || result_ready;
    assign s1_ready   = !s1_valid_reg || out_ready;
    assign item_ready = !item.last || s1_ready;
    assign fire       = item_valid && item_ready;

    // Bank update for the selected tile column.
    always_comb
    begin
        fresh      = count_reg[item.bank] == '0;
        min_next   = (fresh || item.pixel < min_reg[item.bank]) ? item.pixel
                                                                : min_reg[item.bank];
        max_next   = (fresh || item.pixel > max_reg[item.bank]) ? item.pixel
                                                                : max_reg[item.bank];
        sum_next   = (fresh ? '0 : sum_reg[item.bank]) + SUM_W'(item.pixel);
        sumsq_next = (fresh ? '0 : sumsq_reg[item.bank]) + SUMSQ_W'(item.square);
        count_next = item.last ? '0 : COUNT_W'(count_reg[item.bank] + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end
        else if (fire)
        begin
            count_reg[item.bank] <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            min_reg[item.bank]   <= min_next;
            max_reg[item.bank]   <= max_next;
            sum_reg[item.bank]   <= sum_next;
            sumsq_reg[item.bank] <= sumsq_next;
        end
    end

    // Tile stage: capture the figures of a completed tile.
    always_comb
    begin
        s1_next.min_val = min_next;
        s1_next.max_val = max_next;
        s1_next.mean    = PIX_W'(sum_next >> MEAN_SHIFT);
        s1_next.sqs     = SQS_W'(sumsq_next >> MEAN_SHIFT);
        s1_next.frame   = item.frame;
        s1_next.tile    = item.tile;
        s1_valid_next   = (fire && item.last) ? 1'b1 :
                          (out_ready ? 1'b0 : s1_valid_reg);
    end

    // Output stage: squared mean and floored difference.
    always_comb
    begin
        mean_sq  = SQ_W'(s1_reg.mean) * SQ_W'(s1_reg.mean);
        var_full = (s1_reg.sqs > SQS_W'(mean_sq)) ? SQS_W'(s1_reg.sqs - SQS_W'(mean_sq))
                                                  : '0;
        result_valid_next = (s1_valid_reg && out_ready) ? 1'b1 :
                            (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item.last)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && out_ready)
        begin
            min_value        <= s1_reg.min_val;
            max_value        <= s1_reg.max_val;
            mean_value       <= s1_reg.mean;
            variance_value   <= VAR_W'(var_full);
            tile_number_out  <= s1_reg.tile;
            frame_number_out <= s1_reg.frame;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

// ===== src/tile_min_max_mean_variance.sv =====
// Tile statistics top level: min, max, mean and variance per tile of a pixel stream.
// A tile's last pixel beat passes the two front-end stages, the queue register, the tile
// stage and the output stage. Throughput: one pixel beat per cycle when nothing stalls;
// the bank update reads and writes a bank in the same cycle.
// Reset clears all valid flags, the queue pointers and both bank counts; no clearing pass.
module tile_min_max_mean_variance #(
    parameter int TILE_W          = 8,
    parameter int TILE_H          = 8,
    parameter int BANK_SELECT_BIT = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [tmmv_pkg::PIX_W-1:0]       pixel_value,
    input  logic [tmmv_pkg::COORD_W-1:0]     x_coord,
    input  logic [tmmv_pkg::COORD_W-1:0]     y_coord,
    input  logic [tmmv_pkg::FRAME_W-1:0]     frame_number,
    input  logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [tmmv_pkg::PIX_W-1:0]       min_value,
    output logic [tmmv_pkg::PIX_W-1:0]       max_value,
    output logic [tmmv_pkg::PIX_W-1:0]       mean_value,
    output logic [tmmv_pkg::VAR_W-1:0]       variance_value,
    output logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number_out,
    output logic [tmmv_pkg::FRAME_W-1:0]     frame_number_out
);
    import tmmv_pkg::*;

    logic       fe_valid, fe_ready;
    tmmv_item_t fe_item;
    logic       be_valid, be_ready;
    tmmv_item_t be_item;

    // Classification front end.
    tmmv_front #(
        .TILE_W          (TILE_W),
        .TILE_H          (TILE_H),
        .BANK_SELECT_BIT (BANK_SELECT_BIT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .frame_number (frame_number),
        .tile_number  (tile_number),
        .item_valid   (fe_valid),
        .item_ready   (fe_ready),
        .item         (fe_item)
    );

    // Decoupling queue.
    tmmv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_item  (fe_item),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_item   (be_item)
    );

    // Accumulation and result back end.
    tmmv_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (be_valid),
        .item_ready       (be_ready),
        .item             (be_item),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .min_value        (min_value),
        .max_value        (max_value),
        .mean_value       (mean_value),
        .variance_value   (variance_value),
        .tile_number_out  (tile_number_out),
        .frame_number_out (frame_number_out)
    );

endmodule

// ===== src/tmmv_checker.sv =====
// Port-level checks for the tile statistics block, bound to the top level.
// Depends on tmmv_pkg for field widths.
module tmmv_port_checks (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             pixel_valid,
    input logic                             pixel_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [tmmv_pkg::PIX_W-1:0]       min_value,
    input logic [tmmv_pkg::PIX_W-1:0]       max_value,
    input logic [tmmv_pkg::PIX_W-1:0]       mean_value,
    input logic [tmmv_pkg::VAR_W-1:0]       variance_value,
    input logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number_out,
    input logic [tmmv_pkg::FRAME_W-1:0]     frame_number_out
);
    import tmmv_pkg::*;

    // A stalled result beat stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(min_value) &&
        $stable(max_value) && $stable(mean_value) && $stable(variance_value) &&
        $stable(tile_number_out) && $stable(frame_number_out))
        else $error("result beat changed while stalled");

    // Minimum and maximum cover the same pixels, so they never cross.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> min_value <= max_value)
        else $error("tile minimum above tile maximum");

    // Leaving reset, no result beat is pending.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

    // Leaving reset, the front end can take a pixel at once.
    a_reset_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> pixel_ready)
        else $error("pixel channel not ready after reset");

endmodule

bind tile_min_max_mean_variance tmmv_port_checks u_checker (.*);

// ===== tb/tmmv_checker.sv =====
// Scoreboard for the tile statistics block: follows both bank accumulators from the
// accepted pixel beats and compares each result beat with the predicted tile figures.
// Depends on tmmv_pkg for the field widths.
module tmmv_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    input  logic                             pixel_ready,
    input  logic [tmmv_pkg::PIX_W-1:0]       pixel_value,
    input  logic [tmmv_pkg::COORD_W-1:0]     x_coord,
    input  logic [tmmv_pkg::COORD_W-1:0]     y_coord,
    input  logic [tmmv_pkg::FRAME_W-1:0]     frame_number,
    input  logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [tmmv_pkg::PIX_W-1:0]       min_value,
    input  logic [tmmv_pkg::PIX_W-1:0]       max_value,
    input  logic [tmmv_pkg::PIX_W-1:0]       mean_value,
    input  logic [tmmv_pkg::VAR_W-1:0]       variance_value,
    input  logic [tmmv_pkg::TILE_TAG_W-1:0]  tile_number_out,
    input  logic [tmmv_pkg::FRAME_W-1:0]     frame_number_out,
    output int                               fail_count,
    output int                               pending_results
);
    import tmmv_pkg::*;

    localparam int TILE_SIDE = 8;
    localparam int BANK_BIT  = 3;
    localparam logic [PIX_W-1:0] MIN_START = 8'd255;

    // Figures of one completed tile, in the order of the result ports.
    typedef struct packed {
        logic [PIX_W-1:0]      min_val;
        logic [PIX_W-1:0]      max_val;
        logic [PIX_W-1:0]      mean;
        logic [VAR_W-1:0]      variance;
        logic [TILE_TAG_W-1:0] tile;
        logic [FRAME_W-1:0]    frame;
    } tile_figures_t;

    logic [PIX_W-1:0]   bank_min   [2];
    logic [PIX_W-1:0]   bank_max   [2];
    logic [SUM_W-1:0]   bank_sum   [2];
    logic [SUMSQ_W-1:0] bank_sumsq [2];
    logic [COUNT_W-1:0] bank_count [2];

    tile_figures_t awaited_figures [$];
    int mismatch_total = 0;
    int owed_total     = 0;

    assign fail_count      = mismatch_total;
    assign pending_results = owed_total;

    // Fold one pixel beat into its bank; on a tile's last pixel queue the tile figures.
    task automatic accumulate_pixel();
        logic               bank;
        logic               fresh;
        logic               closes;
        logic [PIX_W-1:0]   lo;
        logic [PIX_W-1:0]   hi;
        logic [SUM_W-1:0]   sum;
        logic [SUMSQ_W-1:0] sumsq;
        logic [SQS_W-1:0]   sqs;
        logic [2*PIX_W-1:0] mean_sq;
        logic [SQS_W-1:0]   spread;
        tile_figures_t      fig;
        bank   = x_coord[BANK_BIT];
        fresh  = (bank_count[bank] == '0);
        closes = (x_coord % TILE_SIDE == TILE_SIDE - 1) &&
                 (y_coord % TILE_SIDE == TILE_SIDE - 1);
        lo     = (fresh || pixel_value < bank_min[bank]) ? pixel_value : bank_min[bank];
        hi     = (fresh || pixel_value > bank_max[bank]) ? pixel_value : bank_max[bank];
        sum    = (fresh ? SUM_W'(0) : bank_sum[bank]) + SUM_W'(pixel_value);
        sumsq  = (fresh ? SUMSQ_W'(0) : bank_sumsq[bank])
                 + SUMSQ_W'(pixel_value) * SUMSQ_W'(pixel_value);

        bank_min[bank]   = lo;
        bank_max[bank]   = hi;
        bank_sum[bank]   = sum;
        bank_sumsq[bank] = sumsq;
        bank_count[bank] = closes ? COUNT_W'(0) : bank_count[bank] + COUNT_W'(1);

        if (closes)
        begin
            // The mean keeps only its low byte; the variance is floored at zero.
            fig.min_val  = lo;
            fig.max_val  = hi;
            fig.mean     = sum[MEAN_SHIFT +: PIX_W];
            sqs          = sumsq[SUMSQ_W-1:MEAN_SHIFT];
            mean_sq      = {{PIX_W{1'b0}}, fig.mean} * {{PIX_W{1'b0}}, fig.mean};
            spread       = (sqs > SQS_W'(mean_sq)) ? sqs - SQS_W'(mean_sq) : SQS_W'(0);
            fig.variance = spread[VAR_W-1:0];
            fig.tile     = tile_number;
            fig.frame    = frame_number;
            awaited_figures.push_back(fig);
        end
    endtask

    function automatic void compare_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_total++;
        end
    endfunction

    // Match a result beat against the oldest tile still owed.
    task automatic check_result();
        tile_figures_t want;
        if (awaited_figures.size() == 0)
        begin
            $display("%0t: result beat with no tile owed, expected none, %s %0d %0d %0d %0d %0d %0d",
                     $time, "actual", min_value, max_value, mean_value, variance_value,
                     tile_number_out, frame_number_out);
            mismatch_total++;
        end
        else
        begin
            want = awaited_figures.pop_front();
            compare_field("min_value", want.min_val, min_value);
            compare_field("max_value", want.max_val, max_value);
            compare_field("mean_value", want.mean, mean_value);
            compare_field("variance_value", want.variance, variance_value);
            compare_field("tile_number_out", want.tile, tile_number_out);
            compare_field("frame_number_out", want.frame, frame_number_out);
        end
    endtask

    // Both channels are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
            begin
                bank_min[b]   = MIN_START;
                bank_max[b]   = '0;
                bank_sum[b]   = '0;
                bank_sumsq[b] = '0;
                bank_count[b] = '0;
            end
            awaited_figures.delete();
            owed_total = 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
                accumulate_pixel();
            if (result_valid && result_ready)
                check_result();
            owed_total = awaited_figures.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the tile statistics testbench: clock, reset, pixel beat stimulus and result stalls.
// Holds the block and the scoreboard side by side; depends on tmmv_pkg and tmmv_checker.
module tb;
    import tmmv_pkg::*;

    typedef enum {SEQ_TILES, SEQ_EARLY, SEQ_LATE, SEQ_NOISE} run_kind_t;
    typedef enum {SHADE_ANY, SHADE_FLAT, SHADE_EXTREME} shade_t;
    typedef enum {SINK_OPEN, SINK_COIN, SINK_PULSE, SINK_HOLD} sink_mode_t;

    localparam int TILE_SIDE    = 8;
    localparam int BANK_BIT     = 3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PIXEL_TARGET = 1250;
    localparam int TILE_TARGET  = 20;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    pixel_valid  = 1'b0;
    logic                    pixel_ready;
    logic [PIX_W-1:0]        pixel_value  = '0;
    logic [COORD_W-1:0]      x_coord      = '0;
    logic [COORD_W-1:0]      y_coord      = '0;
    logic [FRAME_W-1:0]      frame_number = '0;
    logic [TILE_TAG_W-1:0]   tile_number  = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic [PIX_W-1:0]        min_value;
    logic [PIX_W-1:0]        max_value;
    logic [PIX_W-1:0]        mean_value;
    logic [VAR_W-1:0]        variance_value;
    logic [TILE_TAG_W-1:0]   tile_number_out;
    logic [FRAME_W-1:0]      frame_number_out;
    int                      fail_count;
    int                      pending_results;

    int         burst_left   = 0;
    int         pixels_sent  = 0;
    int         tiles_closed = 0;
    int         idle_cycles  = 0;
    sink_mode_t sink_mode    = SINK_OPEN;
    int         sink_left    = 0;

    tile_min_max_mean_variance i_dut (.*);

    tmmv_checker i_checker (.*);

    always #4 clk = ~clk;

    // Result side stalls on its own schedule: open, coin toss, sparse pulses or a hold.
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = (sink_mode == SINK_HOLD) ? $urandom_range(1, 30)
                                                 : $urandom_range(5, 80);
        end
        sink_left = sink_left - 1;
        case (sink_mode)
            SINK_HOLD:  result_ready <= 1'b0;
            SINK_COIN:  result_ready <= 1'($urandom_range(0, 1));
            SINK_PULSE: result_ready <= (sink_left % 3 == 0);
            default:    result_ready <= 1'b1;
        endcase
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [PIX_W-1:0] draw_pixel(shade_t shade, logic [PIX_W-1:0] base);
        int v;
        case (shade)
            SHADE_FLAT:    v = int'(base) + $urandom_range(0, 3);
            SHADE_EXTREME: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            default:       v = $urandom_range(0, 255);
        endcase
        return (v > 255) ? PIX_W'(255) : PIX_W'(v);
    endfunction

    // Moves a position off a tile's last pixel by flipping the low row bit.
    function automatic logic [COORD_W-1:0] off_corner(logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y);
        if (x % TILE_SIDE == TILE_SIDE - 1 && y % TILE_SIDE == TILE_SIDE - 1)
            return {y[COORD_W-1:1], ~y[0]};
        return y;
    endfunction

    // Offer one pixel beat and hold it until accepted; bursts are split by random gaps.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [FRAME_W-1:0] frame,
                              input logic [TILE_TAG_W-1:0] tile);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel_valid  <= 1'b1;
        pixel_value  <= pix;
        x_coord      <= x;
        y_coord      <= y;
        frame_number <= frame;
        tile_number  <= tile;
        pixels_sent++;
        if (x % TILE_SIDE == TILE_SIDE - 1 && y % TILE_SIDE == TILE_SIDE - 1)
            tiles_closed++;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
    endtask

    // Stop offering beats until every owed tile result has come back.
    task automatic wait_for_results();
        pixel_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        run_kind_t             kind;
        shade_t                shade;
        int                    pick;
        int                    count;
        int                    ncols;
        logic                  bank;
        logic [PIX_W-1:0]      base;
        logic [FRAME_W-1:0]    frame;
        logic [TILE_TAG_W-1:0] tile;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a one-pixel tile at the far corner with every field at its top.
        send_pixel(8'd255, 12'd4095, 12'd4095, 8'd255, 16'hFFFF);
        // Early completion of bank 0 after a handful of pixels, extremes among them.
        send_pixel(8'd0, 12'd0, 12'd0, 8'd0, 16'd0);
        send_pixel(8'd255, 12'd1, 12'd0, 8'd1, 16'd1);
        send_pixel(8'd128, 12'd2, 12'd6, 8'd2, 16'd2);
        send_pixel(8'd37, 12'd6, 12'd7, 8'd3, 16'd3);
        send_pixel(8'd1, 12'd7, 12'd7, 8'hA5, 16'h5A5A);
        // Bank 1 gathers pixels far apart, one on the last column but not the last row.
        send_pixel(8'd200, 12'd8, 12'd0, 8'd4, 16'd4);
        send_pixel(8'd17, 12'd4088, 12'd4094, 8'd5, 16'd5);
        send_pixel(8'd99, 12'd4095, 12'd6, 8'd6, 16'd6);
        send_pixel(8'd255, 12'd15, 12'd15, 8'h5A, 16'hA5A5);
        // A dark single-pixel tile, then a short flat run of equal pixels that closes bank 0.
        send_pixel(8'd0, 12'd7, 12'd4087, 8'd7, 16'd7);
        send_pixel(8'd100, 12'h800, 12'd16, 8'd8, 16'd8);
        send_pixel(8'd100, 12'h801, 12'd17, 8'd8, 16'd8);
        send_pixel(8'd100, 12'h802, 12'd18, 8'd8, 16'd8);
        send_pixel(8'd100, 12'h807, 12'd23, 8'd8, 16'd9);
        wait_for_results();

        // Random: mostly whole tiles and short or overlong tiles, with some noise.
        while (pixels_sent < PIXEL_TARGET || tiles_closed < TILE_TARGET)
        begin
            pick  = $urandom_range(0, 99);
            kind  = (pick < 35) ? SEQ_TILES : (pick < 75) ? SEQ_EARLY :
                    (pick < 83) ? SEQ_LATE : SEQ_NOISE;
            shade = shade_t'($urandom_range(0, 2));
            base  = PIX_W'($urandom_range(0, 255));
            frame = FRAME_W'($urandom);
            tile  = TILE_TAG_W'($urandom);
            case (kind)
                SEQ_TILES:
                begin
                    // One or two tile columns scanned row by row.
                    ncols = $urandom_range(1, 2);
                    x = COORD_W'($urandom_range(0, 512 - ncols) * TILE_SIDE);
                    y = COORD_W'($urandom_range(0, 511) * TILE_SIDE);
                    for (int row = 0; row < TILE_SIDE; row++)
                        for (int col = 0; col < ncols * TILE_SIDE; col++)
                            send_pixel(draw_pixel(shade, base), COORD_W'(x + col),
                                       COORD_W'(y + row), frame,
                                       TILE_TAG_W'(tile + col / TILE_SIDE));
                end
                SEQ_EARLY, SEQ_LATE:
                begin
                    // Scattered pixels into one bank, then its last pixel. Long runs
                    // push the mean past a byte, floor the variance or wrap the count.
                    bank  = 1'($urandom_range(0, 1));
                    count = (kind == SEQ_LATE) ? $urandom_range(65, 140)
                                               : $urandom_range(0, 20);
                    if (kind == SEQ_LATE && $urandom_range(0, 1) == 1)
                        wait_for_results();
                    repeat (count)
                    begin
                        x = COORD_W'($urandom);
                        x[BANK_BIT] = bank;
                        y = COORD_W'($urandom);
                        send_pixel(draw_pixel(shade, base), x, off_corner(x, y), frame, tile);
                    end
                    x = COORD_W'($urandom) | COORD_W'(TILE_SIDE - 1);
                    x[BANK_BIT] = bank;
                    y = COORD_W'($urandom) | COORD_W'(TILE_SIDE - 1);
                    send_pixel(draw_pixel(shade, base), x, y, frame, tile);
                end
                default:
                begin
                    count = $urandom_range(1, 20);
                    repeat (count)
                        send_pixel(PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                                   FRAME_W'($urandom), TILE_TAG_W'($urandom));
                end
            endcase
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tmmv_pkg.sv
src/tmmv_front.sv
src/tmmv_queue.sv
src/tmmv_back.sv
src/tile_min_max_mean_variance.sv
src/tmmv_checker.sv
tb/tmmv_checker.sv
tb/tb.sv
